[hdl/rrc_pkg.sv]
// ----------------------------------------------------------------------------
// rrc_pkg: shared types, constants and helpers
// Payload words, the log2 cell word, the reference unit states and the
// leading-one and normalize helpers used on both the target and reference paths.
// ----------------------------------------------------------------------------
package rrc_pkg;

   localparam int CoordWidth = 16;
   localparam int AmpWidth   = 16;
   localparam int RefWidth   = 16;
   localparam int FracW      = 16;                   // log2 fraction bits
   localparam int MantFrac   = 30;                   // mantissa is Q1.30
   localparam int MantW      = MantFrac + 1;
   localparam int SumW       = 2 * CoordWidth;       // x^2 + y^2
   localparam int SqW        = 2 * CoordWidth - 1;
   localparam int ExpW       = $clog2(SumW);
   localparam int LogW       = ExpW + FracW;         // unsigned log2, Q16
   localparam int TlW        = LogW + 2;             // signed log2 difference
   localparam int KW         = 19;
   localparam int ProdW      = TlW + KW + 1;
   localparam int CntW       = $clog2(FracW + 1);
   localparam int PaddrW     = 2;

   localparam logic [KW-1:0]       LogK        = KW'(394566);   // 20*log10(2), Q16
   localparam int                  OriginLog   = -257659;       // 2*log2(0.256), Q16
   localparam logic [RefWidth-1:0] RefReset    = RefWidth'(256);
   localparam logic [LogW-1:0]     RefLogReset = LogW'(524288); // log2(256), Q16
   localparam logic [PaddrW-1:0]   RefAddr     = PaddrW'(0);

   typedef struct packed {
      logic signed [CoordWidth-1:0] pos_x;
      logic signed [CoordWidth-1:0] pos_y;
      logic signed [AmpWidth-1:0]   amplitude_in;
   } req_type;

   typedef struct packed {
      logic signed [AmpWidth-1:0] amplitude_out;
      logic                       saturated;
   } rsp_type;

   // word handed from cell to cell
   typedef struct packed {
      logic                       valid;
      logic                       origin;
      logic signed [AmpWidth-1:0] amp;
      logic [ExpW-1:0]            exp;
      logic [FracW-1:0]           frac;
      logic [MantW-1:0]           mant;
   } node_type;

   typedef enum logic {
      REF_IDLE,
      REF_RUN
   } ref_state_type;

   function automatic logic [ExpW-1:0] lead_one(input logic [SumW-1:0] v);
      logic [ExpW-1:0] n;
      n = '0;
      for (int i = 0; i < SumW; i++) begin
         if (v[i]) n = ExpW'(i);
      end
      return n;
   endfunction

   // v * 2^(30-n), truncated to Q1.30
   function automatic logic [MantW-1:0] mant_norm(input logic [SumW-1:0] v,
                                                  input logic [ExpW-1:0] n);
      logic [SumW+MantFrac-1:0] wide;
      wide = {v, {MantFrac{1'b0}}} >> n;
      return wide[MantW-1:0];
   endfunction

endpackage

[hdl/rrc_cell.sv]
// ----------------------------------------------------------------------------
// rrc_cell: one log2 fraction step
// Squares the Q1.30 mantissa, emits one fraction bit and renormalizes;
// the word is registered and passed to the next cell.
// ----------------------------------------------------------------------------
module rrc_cell (
   input  logic              clock,
   input  logic              reset,
   input  rrc_pkg::node_type node_i,
   output rrc_pkg::node_type node_o
);
   import rrc_pkg::*;

   logic [2*MantW-1:0] sq;
   logic [MantW:0]     top;
   node_type           node_in;
   node_type           node_ff;

   always_comb begin
      sq      = node_i.mant * node_i.mant;
      top     = sq[2*MantW-1:MantFrac];
      node_in = node_i;
      node_in.frac = {node_i.frac[FracW-2:0], top[MantW]};
      node_in.mant = top[MantW] ? top[MantW:1] : top[MantW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) node_ff <= '0;
      else       node_ff <= node_in;
   end

   assign node_o = node_ff;

endmodule

[hdl/rrc_front.sv]
// ----------------------------------------------------------------------------
// rrc_front: range front end
// Magnitudes, squares, sum, leading-one position and mantissa normalize,
// one step per register stage.
// ----------------------------------------------------------------------------
module rrc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  rrc_pkg::req_type  req_data,
   output rrc_pkg::node_type node_o
);
   import rrc_pkg::*;

   logic                       v1_ff, v2_ff, v3_ff, v4_ff;
   logic [CoordWidth-1:0]      ax_ff, ay_ff;
   logic [CoordWidth-1:0]      ax_in, ay_in;
   logic signed [AmpWidth-1:0] amp1_ff, amp2_ff, amp3_ff, amp4_ff;
   logic [SqW-1:0]             sqx_ff, sqy_ff;
   logic [SumW-1:0]            sum_ff, sum4_ff;
   logic [ExpW-1:0]            exp_ff;
   logic                       origin_ff;
   node_type                   node_ff;
   node_type                   node_in;

   always_comb begin
      ax_in = req_data.pos_x[CoordWidth-1] ? CoordWidth'(-req_data.pos_x)
                                           : CoordWidth'(req_data.pos_x);
      ay_in = req_data.pos_y[CoordWidth-1] ? CoordWidth'(-req_data.pos_y)
                                           : CoordWidth'(req_data.pos_y);
      node_in        = '0;
      node_in.valid  = v4_ff;
      node_in.origin = origin_ff;
      node_in.amp    = amp4_ff;
      node_in.exp    = exp_ff;
      node_in.mant   = mant_norm(sum4_ff, exp_ff);
   end

   always_ff @(posedge clock) begin
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      amp1_ff   <= req_data.amplitude_in;
      sqx_ff    <= SqW'(SumW'(ax_ff) * SumW'(ax_ff));
      sqy_ff    <= SqW'(SumW'(ay_ff) * SumW'(ay_ff));
      amp2_ff   <= amp1_ff;
      sum_ff    <= SumW'(sqx_ff) + SumW'(sqy_ff);
      amp3_ff   <= amp2_ff;
      exp_ff    <= lead_one(sum_ff);
      origin_ff <= (sum_ff == '0);
      sum4_ff   <= sum_ff;
      amp4_ff   <= amp3_ff;
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         node_ff <= '0;
      end else begin
         v1_ff   <= accept;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
         node_ff <= node_in;
      end
   end

   assign node_o = node_ff;

endmodule

[hdl/rrc_ref.sv]
// ----------------------------------------------------------------------------
// rrc_ref: reference distance register and its log2
// Holds ref_distance and, after each write, runs its log2 through one
// shared cell for the fraction steps.
// ----------------------------------------------------------------------------
module rrc_ref (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rrc_pkg::PaddrW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       busy,
   output logic [rrc_pkg::LogW-1:0]   log_ref
);
   import rrc_pkg::*;

   ref_state_type       state_ff, state_in;
   logic [RefWidth-1:0] ref_ff;
   logic [RefWidth-1:0] ref_eff;
   logic [CntW-1:0]     cnt_ff;
   logic [LogW-1:0]     log_ref_ff;
   logic                wr;
   logic                done;
   logic [ExpW-1:0]     init_exp;
   node_type            init_node;
   node_type            feed;
   node_type            step;

   assign wr = psel && penable && pwrite;

   rrc_cell u_cell (
      .clock  (clock),
      .reset  (reset),
      .node_i (feed),
      .node_o (step)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         REF_IDLE: if (wr) state_in = REF_RUN;
         REF_RUN:  if (done && !wr) state_in = REF_IDLE;
         default:  state_in = REF_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ref_eff        = (ref_ff == '0) ? RefWidth'(1) : ref_ff;
      init_exp       = lead_one(SumW'(ref_eff));
      init_node      = '0;
      init_node.exp  = init_exp;
      init_node.mant = mant_norm(SumW'(ref_eff), init_exp);
      done           = 1'b0;
      feed           = step;
      unique case (state_ff)
         REF_IDLE: feed = init_node;
         REF_RUN: begin
            if (cnt_ff == '0) feed = init_node;
            done = (cnt_ff == CntW'(FracW));
         end
         default: feed = init_node;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= REF_IDLE;
         ref_ff     <= RefReset;
         log_ref_ff <= RefLogReset;
         cnt_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (wr) ref_ff <= pwdata[RefWidth-1:0];
         // a new write restarts the steps on the new value
         if (state_ff == REF_RUN && !wr) cnt_ff <= cnt_ff + CntW'(1);
         else                            cnt_ff <= '0;
         if (done) log_ref_ff <= {step.exp, step.frac};
      end
   end

   assign prdata  = (paddr == RefAddr) ? {{(32-RefWidth){1'b0}}, ref_ff} : '0;
   assign busy    = (state_ff == REF_RUN) || wr;
   assign log_ref = log_ref_ff;

endmodule

[hdl/rrc_back.sv]
// ----------------------------------------------------------------------------
// rrc_back: dB scaling and saturation
// Forms the log2 difference, scales it by 20*log10(2), rounds to Q8.8 and
// subtracts it from the amplitude with saturation.
// ----------------------------------------------------------------------------
module rrc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  rrc_pkg::node_type        node_i,
   input  logic [rrc_pkg::LogW-1:0] log_ref,
   output logic                     rsp_strobe,
   output rrc_pkg::rsp_type         rsp_data
);
   import rrc_pkg::*;

   localparam int TdbW = ProdW - 23;
   localparam int ResW = TdbW + 2;

   logic                       v1_ff, v2_ff, v3_ff, strobe_ff;
   logic signed [AmpWidth-1:0] amp1_ff, amp2_ff, amp3_ff;
   logic signed [TlW-1:0]      ls_w, ref2, tl_in, tl_ff;
   logic signed [ProdW-1:0]    prod_ff;
   logic [ProdW-1:0]           mag_in, mag_ff;
   logic                       neg_ff;
   logic [ProdW:0]             rnd;
   logic signed [ResW-1:0]     tdb, res;
   rsp_type                    rsp_in, rsp_ff;

   always_comb begin
      ls_w  = node_i.origin ? TlW'(OriginLog) : TlW'({node_i.exp, node_i.frac});
      ref2  = TlW'({log_ref, 1'b0});
      tl_in = ls_w - ref2;
      mag_in = prod_ff[ProdW-1] ? ProdW'(-prod_ff) : ProdW'(prod_ff);
      // round half away from zero on the magnitude
      rnd = {1'b0, mag_ff} + (ProdW+1)'(1 << 23);
      tdb = neg_ff ? -ResW'(rnd[ProdW:24]) : ResW'(rnd[ProdW:24]);
      res = ResW'(amp3_ff) - tdb;
      rsp_in.saturated = 1'b1;
      if (res > ResW'(32767))       rsp_in.amplitude_out = 16'sh7fff;
      else if (res < -ResW'(32768)) rsp_in.amplitude_out = 16'sh8000;
      else begin
         rsp_in.amplitude_out = AmpWidth'(res);
         rsp_in.saturated     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      tl_ff   <= tl_in;
      amp1_ff <= node_i.amp;
      prod_ff <= tl_ff * $signed({1'b0, LogK});
      amp2_ff <= amp1_ff;
      mag_ff  <= mag_in;
      neg_ff  <= prod_ff[ProdW-1];
      amp3_ff <= amp2_ff;
      rsp_ff  <= rsp_in;
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v1_ff     <= node_i.valid;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         strobe_ff <= v3_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[hdl/radar_range_compensation.sv]
// ----------------------------------------------------------------------------
// radar_range_compensation: fourth-power range loss compensation
// Corrects a detection's dB amplitude by 40*log10(d/d_ref), saturated.
// ----------------------------------------------------------------------------
// usage:
//   a detection word (pos_x, pos_y, amplitude_in) is taken on req_data at a
//   clock edge where start is high and busy is low; one new word may enter
//   every cycle while busy is low, so the throughput is one word per cycle
//   each result comes on rsp_data for a single cycle marked by rsp_strobe, in
//   input order; the receiver cannot stall, and results are never held back
//   the pipeline holds five front-end stages, a chain of sixteen log2 cells
//   (one squaring multiplier each, one fraction bit per cell) and four scaling
//   and rounding stages
//   ref_distance is read on the apb port at address 0 and written at any
//   address; busy is high in a write's access cycle and after it while its
//   log2 is run through a single cell
//   reset clears the pipeline and sets ref_distance to 1 m, with its log2
//   ready at once
// ----------------------------------------------------------------------------
module radar_range_compensation (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  rrc_pkg::req_type           req_data,
   output logic                       rsp_strobe,
   output rrc_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rrc_pkg::PaddrW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import rrc_pkg::*;

   logic            accept;
   logic [LogW-1:0] log_ref;
   node_type        chain [0:FracW];

   assign accept = start && !busy;
   assign pready = 1'b1;

   rrc_ref u_ref (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .busy    (busy),
      .log_ref (log_ref)
   );

   rrc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .node_o   (chain[0])
   );

   for (genvar g = 0; g < FracW; g++) begin : g_cells
      rrc_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .node_i (chain[g]),
         .node_o (chain[g+1])
      );
   end

   rrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .node_i     (chain[FracW]),
      .log_ref    (log_ref),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
